>>> rtl/jqq_pkg.sv
// Package for the JPEG quality quantizer: widths, payload types, base tables, scale rule.
package jqq_pkg;

    localparam int BLOCK_SIZE   = 64;
    localparam int IDX_W        = $clog2(BLOCK_SIZE);
    localparam int COEF_W       = 16;
    localparam int QUANT_W      = 12;
    localparam int DIV_W        = 8;
    localparam int QUAL_W       = 7;
    localparam int SCALE_W      = 13;
    localparam int BASE_W       = 7;
    localparam int PROD_W       = BASE_W + SCALE_W;
    localparam int NUM_W        = 12;
    localparam int REC100_W     = 13;
    localparam int REC100       = 5243;
    localparam int REC100_SHIFT = 19;
    localparam int X_W          = 15;
    localparam int ROUND_100    = 50;
    localparam int SAT_LIMIT    = 25600;
    localparam int QUAL_RESET   = 50;
    localparam int QUANT_MAX    = 2047;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [IDX_W-1:0]         coef_index;
        logic                     is_chroma;
    } coef_in_t;

    typedef struct packed {
        logic signed [QUANT_W-1:0] quantized_value;
        logic [DIV_W-1:0]          divisor_used;
    } quant_out_t;

    // Sign, magnitude and scaled divisor of one coefficient on its way to the divider.
    typedef struct packed {
        logic              neg;
        logic [COEF_W-1:0] mag;
        logic [DIV_W-1:0]  divisor;
    } front_t;

    localparam logic [BASE_W-1:0] LUM_BASE [BLOCK_SIZE] = '{
        7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
        7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
        7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
        7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
        7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
        7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
        7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
        7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
    };

    localparam logic [BASE_W-1:0] CHR_BASE [BLOCK_SIZE] = '{
        7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
    };

    function automatic logic [BASE_W-1:0] base_entry(input logic chroma,
                                                     input logic [IDX_W-1:0] idx);
        return chroma ? CHR_BASE[idx] : LUM_BASE[idx];
    endfunction

    // Quality scaling: 5000/q below 50, otherwise 200-2q; quality clamped to 1..100.
    function automatic logic [SCALE_W-1:0] scale_of(input logic [QUAL_W-1:0] q);
        logic [QUAL_W-1:0]  qc;
        logic [SCALE_W-1:0] s;
        qc = q;
        if (q == '0)
        begin
            qc = QUAL_W'(1);
        end
        else if (q > QUAL_W'(100))
        begin
            qc = QUAL_W'(100);
        end
        case (qc)
            7'd1:    s = 13'd5000;
            7'd2:    s = 13'd2500;
            7'd3:    s = 13'd1666;
            7'd4:    s = 13'd1250;
            7'd5:    s = 13'd1000;
            7'd6:    s = 13'd833;
            7'd7:    s = 13'd714;
            7'd8:    s = 13'd625;
            7'd9:    s = 13'd555;
            7'd10:   s = 13'd500;
            7'd11:   s = 13'd454;
            7'd12:   s = 13'd416;
            7'd13:   s = 13'd384;
            7'd14:   s = 13'd357;
            7'd15:   s = 13'd333;
            7'd16:   s = 13'd312;
            7'd17:   s = 13'd294;
            7'd18:   s = 13'd277;
            7'd19:   s = 13'd263;
            7'd20:   s = 13'd250;
            7'd21:   s = 13'd238;
            7'd22:   s = 13'd227;
            7'd23:   s = 13'd217;
            7'd24:   s = 13'd208;
            7'd25:   s = 13'd200;
            7'd26:   s = 13'd192;
            7'd27:   s = 13'd185;
            7'd28:   s = 13'd178;
            7'd29:   s = 13'd172;
            7'd30:   s = 13'd166;
            7'd31:   s = 13'd161;
            7'd32:   s = 13'd156;
            7'd33:   s = 13'd151;
            7'd34:   s = 13'd147;
            7'd35:   s = 13'd142;
            7'd36:   s = 13'd138;
            7'd37:   s = 13'd135;
            7'd38:   s = 13'd131;
            7'd39:   s = 13'd128;
            7'd40:   s = 13'd125;
            7'd41:   s = 13'd121;
            7'd42:   s = 13'd119;
            7'd43:   s = 13'd116;
            7'd44:   s = 13'd113;
            7'd45:   s = 13'd111;
            7'd46:   s = 13'd108;
            7'd47:   s = 13'd106;
            7'd48:   s = 13'd104;
            7'd49:   s = 13'd102;
            default: s = SCALE_W'(200 - 2 * int'(qc));
        endcase
        return s;
    endfunction

endpackage

>>> rtl/jqq_divisor.sv
// Two-stage front end: table lookup and quality scaling, then divide by 100 and clamp.
module jqq_divisor
    import jqq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SCALE_W-1:0] scale,
    input  logic               in_valid,
    output logic               in_ready,
    input  coef_in_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output front_t             out_data
);

    logic                     s1_valid_reg;
    logic                     s1_neg_reg;
    logic [COEF_W-1:0]        s1_mag_reg;
    logic [PROD_W-1:0]        s1_prod_reg;
    logic                     s2_valid_reg;
    front_t                   s2_data_reg;

    logic                     s1_ready;
    logic                     s2_ready;
    logic                     s1_neg_next;
    logic [COEF_W-1:0]        s1_mag_next;
    logic [PROD_W-1:0]        s1_prod_next;
    logic [PROD_W-1:0]        x_sum;
    logic [X_W+REC100_W-1:0]  x_mul;
    logic [DIV_W-1:0]         div_next;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        s1_neg_next  = in_data.coefficient[COEF_W-1];
        s1_mag_next  = s1_neg_next ? (~in_data.coefficient + 1'b1) : in_data.coefficient;
        s1_prod_next = PROD_W'(base_entry(in_data.is_chroma, in_data.coef_index))
                       * PROD_W'(scale);
    end

    // Division by 100 is a reciprocal multiply, exact for every sum below the clamp limit.
    always_comb
    begin
        x_sum = s1_prod_reg + PROD_W'(ROUND_100);
        x_mul = x_sum[X_W-1:0] * REC100_W'(REC100);
        if (x_sum >= PROD_W'(SAT_LIMIT))
        begin
            div_next = '1;
        end
        else
        begin
            div_next = x_mul[REC100_SHIFT +: DIV_W];
        end
        if (div_next == '0)
        begin
            div_next = DIV_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_neg_reg  <= s1_neg_next;
            s1_mag_reg  <= s1_mag_next;
            s1_prod_reg <= s1_prod_next;
        end
        if (s2_ready)
        begin
            s2_data_reg.neg     <= s1_neg_reg;
            s2_data_reg.mag     <= s1_mag_reg;
            s2_data_reg.divisor <= div_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

>>> rtl/jqq_div_pipe.sv
// Rounded magnitude divide, one quotient bit per stage, sign, positive saturation.
module jqq_div_pipe
    import jqq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  front_t     in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output quant_out_t out_data
);

    // Stage 0 forms the rounded dividend, stages 1..NUM_W each resolve one bit,
    // the last stage applies the sign.
    localparam int STAGES = NUM_W + 2;
    localparam int FMT    = NUM_W + 1;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   rdy;

    logic [NUM_W-1:0]  num_reg [NUM_W+1];
    logic [DIV_W-1:0]  rem_reg [NUM_W+1];
    logic [DIV_W-1:0]  dvs_reg [NUM_W+1];
    logic              neg_reg [NUM_W+1];
    quant_out_t        out_reg;

    logic [COEF_W-1:0] sum_next;
    logic [NUM_W-1:0]  quo;
    logic [QUANT_W-1:0] res_next;

    assign rdy[STAGES] = out_ready;

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_rdy
            assign rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    endgenerate

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Adding 8d before dividing by 16d rounds halves away from zero on the magnitude.
    assign sum_next = in_data.mag + COEF_W'({in_data.divisor, 3'b000});

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            num_reg[0] <= sum_next[COEF_W-1 -: NUM_W];
            rem_reg[0] <= '0;
            dvs_reg[0] <= in_data.divisor;
            neg_reg[0] <= in_data.neg;
        end
    end

    generate
        for (s = 1; s <= NUM_W; s++)
        begin : g_step
            logic [DIV_W:0]   trial;
            logic             ge;
            logic [DIV_W-1:0] rem_next;
            logic [NUM_W-1:0] num_next;

            // The dividend shifts out at the top while quotient bits shift in below.
            always_comb
            begin
                trial    = {rem_reg[s-1], num_reg[s-1][NUM_W-1]};
                ge       = trial >= {1'b0, dvs_reg[s-1]};
                rem_next = ge ? DIV_W'(trial - {1'b0, dvs_reg[s-1]}) : trial[DIV_W-1:0];
                num_next = {num_reg[s-1][NUM_W-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s])
                begin
                    num_reg[s] <= num_next;
                    rem_reg[s] <= rem_next;
                    dvs_reg[s] <= dvs_reg[s-1];
                    neg_reg[s] <= neg_reg[s-1];
                end
            end
        end
    endgenerate

    always_comb
    begin
        quo = num_reg[NUM_W];
        if (neg_reg[NUM_W])
        begin
            res_next = QUANT_W'(~quo + 1'b1);
        end
        else if (quo > NUM_W'(QUANT_MAX))
        begin
            res_next = QUANT_W'(QUANT_MAX);
        end
        else
        begin
            res_next = QUANT_W'(quo);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[FMT])
        begin
            out_reg.quantized_value <= $signed(res_next);
            out_reg.divisor_used    <= dvs_reg[NUM_W];
        end
    end

    assign out_valid = vld_reg[FMT];
    assign out_data  = out_reg;

endmodule

>>> rtl/jpeg_quality_quantizer_unit.sv
// Throughput: one item per cycle while out_ready stays high; each of the 16 stages
// holds one item and moves on whenever the stage after it is empty or moving, so
// bubbles close up under a stall.
// The divide runs one quotient bit per stage over 12 stages.
// Reset empties every stage and sets the quality back to 50.
module jpeg_quality_quantizer_unit
    import jqq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [QUAL_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  coef_in_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output quant_out_t        out_data
);

    logic [SCALE_W-1:0] scale_reg;
    logic               mid_valid;
    logic               mid_ready;
    front_t             mid_data;

    // Only the table scale derived from the quality is kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= scale_of(QUAL_W'(QUAL_RESET));
        end
        else if (cfg_we)
        begin
            scale_reg <= scale_of(cfg_wdata);
        end
    end

    jqq_divisor u_divisor
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .scale     (scale_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    jqq_div_pipe u_div_pipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
